[design/nteo_pkg.sv]
// shared constants, types and codes for the neighbour table
package nteo_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int NODE_W = 32;
  localparam int STAMP_W = 32;
  localparam int SLOT_W = 5;
  localparam int COUNT_W = 6;

  localparam logic OP_HEARD = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_APPENDED = 2'd1,
    OUT_REPLACED = 2'd2,
    OUT_CLEARED  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OLDEST
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0]  id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

[design/nteo_table.sv]
// neighbour table storage: one write port, one registered read port
module nteo_table (
  input  logic            clk,
  input  nteo_pkg::tbl_wr_t wr,
  input  nteo_pkg::tbl_rd_t rd,
  output nteo_pkg::entry_t  rdata
);

  nteo_pkg::entry_t mem [nteo_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

[design/neighbour_table_oldest_eviction.sv]
// neighbour table top: sequencer walking the table through one read port
// clear completes from idle; a lookup scans the used entries in order until a hit
// a miss appends when there is room; with the table full and the node absent,
// a second pass over all entries finds the oldest stamp and overwrites that entry
// busy drops in the strobe cycle, so the next transaction can be taken there
// reset clears sequencer and cnt, not entry_count; table contents stay unwritten
module neighbour_table_oldest_eviction (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [31:0] node_number,
  input  logic [31:0] now_time,
  output logic        busy,
  output logic        done,
  output logic [4:0]  slot_index,
  output logic [1:0]  outcome,
  output logic [31:0] replaced_node,
  output logic [5:0]  entry_count
);

  nteo_pkg::state_t state, state_next;
  logic [nteo_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [nteo_pkg::CNT_W-1:0] idx, idx_next;
  logic rd_pend;
  logic [nteo_pkg::IDX_W-1:0] rd_idx;
  logic [nteo_pkg::NODE_W-1:0] node, node_next;
  logic [nteo_pkg::STAMP_W-1:0] now, now_next;
  logic [nteo_pkg::STAMP_W-1:0] best_stamp, best_stamp_next;
  logic [nteo_pkg::NODE_W-1:0] best_id, best_id_next;
  logic [nteo_pkg::IDX_W-1:0] best_idx, best_idx_next;
  logic done_next;
  logic [nteo_pkg::SLOT_W-1:0] slot_q, slot_next;
  nteo_pkg::outcome_t outcome_q, outcome_next;
  logic [nteo_pkg::NODE_W-1:0] replaced_q, replaced_next;
  logic [nteo_pkg::COUNT_W-1:0] count_q, count_next;

  nteo_pkg::tbl_wr_t wr;
  nteo_pkg::tbl_rd_t rd;
  nteo_pkg::entry_t rdata;

  nteo_table u_table (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  assign busy = (state != nteo_pkg::ST_IDLE);
  assign slot_index = slot_q;
  assign outcome = outcome_q;
  assign replaced_node = replaced_q;
  assign entry_count = count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nteo_pkg::ST_IDLE;
      cnt <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rd_pend <= rd.re;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    rd_idx <= rd.addr;
    node <= node_next;
    now <= now_next;
    best_stamp <= best_stamp_next;
    best_id <= best_id_next;
    best_idx <= best_idx_next;
    slot_q <= slot_next;
    outcome_q <= outcome_next;
    replaced_q <= replaced_next;
    count_q <= count_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    idx_next = idx;
    node_next = node;
    now_next = now;
    best_stamp_next = best_stamp;
    best_id_next = best_id;
    best_idx_next = best_idx;
    done_next = 1'b0;
    slot_next = slot_q;
    outcome_next = outcome_q;
    replaced_next = replaced_q;
    count_next = count_q;
    wr.we = 1'b0;
    wr.addr = rd_idx;
    wr.data.id = node;
    wr.data.stamp = now;
    rd.re = 1'b0;
    rd.addr = idx[nteo_pkg::IDX_W-1:0];

    case (state)
      nteo_pkg::ST_IDLE: begin
        if (start) begin
          if (op == nteo_pkg::OP_CLEAR) begin
            cnt_next = '0;
            slot_next = '0;
            outcome_next = nteo_pkg::OUT_CLEARED;
            replaced_next = '0;
            count_next = '0;
            done_next = 1'b1;
          end else begin
            node_next = node_number;
            now_next = now_time;
            idx_next = '0;
            state_next = nteo_pkg::ST_SCAN;
          end
        end
      end

      nteo_pkg::ST_SCAN: begin
        if (rd_pend && (rdata.id == node)) begin
          // hit: refresh stamp
          wr.we = 1'b1;
          wr.addr = rd_idx;
          slot_next = nteo_pkg::SLOT_W'(rd_idx);
          outcome_next = nteo_pkg::OUT_FOUND;
          replaced_next = '0;
          count_next = nteo_pkg::COUNT_W'(cnt);
          done_next = 1'b1;
          state_next = nteo_pkg::ST_IDLE;
        end else if (idx < cnt) begin
          rd.re = 1'b1;
          idx_next = idx + nteo_pkg::CNT_W'(1);
        end else if (!rd_pend) begin
          if (cnt < nteo_pkg::CNT_W'(nteo_pkg::TABLE_DEPTH)) begin
            // miss with room: append
            wr.we = 1'b1;
            wr.addr = cnt[nteo_pkg::IDX_W-1:0];
            cnt_next = cnt + nteo_pkg::CNT_W'(1);
            slot_next = nteo_pkg::SLOT_W'(cnt);
            outcome_next = nteo_pkg::OUT_APPENDED;
            replaced_next = '0;
            count_next = nteo_pkg::COUNT_W'(cnt + nteo_pkg::CNT_W'(1));
            done_next = 1'b1;
            state_next = nteo_pkg::ST_IDLE;
          end else begin
            idx_next = '0;
            state_next = nteo_pkg::ST_OLDEST;
          end
        end
      end

      nteo_pkg::ST_OLDEST: begin
        if (rd_pend && ((rd_idx == '0) || (rdata.stamp < best_stamp))) begin
          best_stamp_next = rdata.stamp;
          best_id_next = rdata.id;
          best_idx_next = rd_idx;
        end
        if (idx < cnt) begin
          rd.re = 1'b1;
          idx_next = idx + nteo_pkg::CNT_W'(1);
        end else if (!rd_pend) begin
          // evict oldest
          wr.we = 1'b1;
          wr.addr = best_idx;
          slot_next = nteo_pkg::SLOT_W'(best_idx);
          outcome_next = nteo_pkg::OUT_REPLACED;
          replaced_next = best_id;
          count_next = nteo_pkg::COUNT_W'(cnt);
          done_next = 1'b1;
          state_next = nteo_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nteo_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= nteo_pkg::CNT_W'(nteo_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(state) != nteo_pkg::ST_IDLE) || $past(start && op))
    else $error("result strobe without a transaction");

  a_replaced_zero: assert property (@(posedge clk) disable iff (rst)
    done && (outcome_q != nteo_pkg::OUT_REPLACED) |-> replaced_q == '0)
    else $error("replaced node set without eviction");

  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    done && (outcome_q == nteo_pkg::OUT_REPLACED)
      |-> cnt == nteo_pkg::CNT_W'(nteo_pkg::TABLE_DEPTH))
    else $error("eviction while table not full");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (nteo_pkg::CNT_W'(rd_idx) < cnt) && (state != nteo_pkg::ST_IDLE))
    else $error("table read outside used entries");

endmodule
